@@ hw/rtl/tsm_pkg.sv @@
// Shared constants for the tape and stack machine: instruction codes,
// status codes and field widths. No dependencies.
`default_nettype none
package tsm_pkg;

  localparam int POS_W  = 20;
  localparam int BYTE_W = 8;
  localparam int STAT_W = 3;

  localparam logic [BYTE_W-1:0] CMD_INC   = 8'h69;
  localparam logic [BYTE_W-1:0] CMD_DEC   = 8'h64;
  localparam logic [BYTE_W-1:0] CMD_CLR   = 8'h63;
  localparam logic [BYTE_W-1:0] CMD_LEFT  = 8'h6c;
  localparam logic [BYTE_W-1:0] CMD_RIGHT = 8'h72;
  localparam logic [BYTE_W-1:0] CMD_PUSH  = 8'h6e;
  localparam logic [BYTE_W-1:0] CMD_POP   = 8'h66;
  localparam logic [BYTE_W-1:0] CMD_FWD   = 8'h73;
  localparam logic [BYTE_W-1:0] CMD_BACK  = 8'h62;
  localparam logic [BYTE_W-1:0] CMD_OUT   = 8'h6f;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd2;
  localparam logic [STAT_W-1:0] ST_RANGE     = 3'd3;
  localparam logic [STAT_W-1:0] ST_ILLEGAL   = 3'd4;
  localparam logic [STAT_W-1:0] ST_HALTED    = 3'd5;

endpackage
`default_nettype wire

@@ hw/rtl/tsm_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none
module tsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ hw/rtl/tape_stack_machine_execute.sv @@
// Top level of the tape and stack machine execution unit.
// Depends on tsm_pkg and tsm_ram.
`default_nettype none
// One instruction is retired per clock cycle while out_ready does not stall
// the result and no clear pass runs. An accepted instruction is held in an
// input register, executed when the result register is free, and its result
// is presented from the result register. The current cell and both of
// its neighbours are cached in registers, and the stack top is cached as
// well, so every tape and stack memory port does at most one write and one
// read per cycle. After reset the tape memory is cleared in a pass over all
// TAPE_DEPTH cells, during which no instruction is taken; configuration
// writes are accepted throughout.
module tape_stack_machine_execute #(
  parameter int TAPE_DEPTH  = 4096,
  parameter int STACK_DEPTH = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [tsm_pkg::POS_W-1:0]   cfg_wr_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [tsm_pkg::BYTE_W-1:0]  in_command,
  input  wire logic [tsm_pkg::POS_W-1:0]   in_position,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [tsm_pkg::POS_W-1:0]   out_next_position,
  output logic      [tsm_pkg::BYTE_W-1:0]  out_out_byte,
  output logic                             out_out_valid,
  output logic      [tsm_pkg::STAT_W-1:0]  out_status
);
  import tsm_pkg::*;

  localparam int TAPE_AW = $clog2(TAPE_DEPTH);
  localparam int STK_AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int STK_CW  = $clog2(STACK_DEPTH + 1);
  localparam logic [TAPE_AW-1:0] TAPE_LAST = TAPE_AW'(TAPE_DEPTH - 1);
  localparam logic [TAPE_AW:0]   TAPE_SIZE = (TAPE_AW + 1)'(TAPE_DEPTH);
  localparam logic [TAPE_AW:0]   TAPE_TWO  = (TAPE_AW + 1)'(2);
  localparam logic [STK_CW-1:0]  STK_FULL  = STK_CW'(STACK_DEPTH);

  // Handshake and input register.
  logic              in_vld_r, in_vld_nxt;
  logic [BYTE_W-1:0] in_cmd_r;
  logic [POS_W-1:0]  in_pos_r;
  logic              out_vld_r, out_vld_nxt;
  logic              fire;
  logic              accept;

  // Result register.
  logic [POS_W-1:0]  res_pos_r, res_pos_nxt;
  logic [BYTE_W-1:0] res_byte_r, res_byte_nxt;
  logic              res_ov_r, res_ov_nxt;
  logic [STAT_W-1:0] res_stat_r, res_stat_nxt;

  // Machine state.
  logic [POS_W-1:0]   plen_r;
  logic [TAPE_AW-1:0] ptr_r, ptr_nxt;
  logic [BYTE_W-1:0]  cell_r, cell_nxt;
  logic [BYTE_W-1:0]  left_r, left_nxt, left_eff;
  logic [BYTE_W-1:0]  right_r, right_nxt, right_eff;
  logic               lpend_r, lpend_nxt;
  logic               rpend_r, rpend_nxt;
  logic [BYTE_W-1:0]  top_r, top_nxt, top_eff;
  logic               tpend_r, tpend_nxt;
  logic [STK_CW-1:0]  cnt_r, cnt_nxt;
  logic               halted_r, halted_nxt;
  logic               clr_active_r, clr_active_nxt;
  logic [TAPE_AW-1:0] clr_addr_r, clr_addr_nxt;

  // Pointer arithmetic.
  logic [TAPE_AW:0]   ptr_x, ptr_p1_x, ptr_p2_x, ptr_m2_x;
  logic [TAPE_AW-1:0] ptr_inc, ptr_dec, ptr_p2, ptr_m2;

  // Memory ports.
  logic               tape_we, tape_re;
  logic [TAPE_AW-1:0] tape_waddr, tape_raddr;
  logic [BYTE_W-1:0]  tape_wdata, tape_rdata;
  logic               stk_we, stk_re;
  logic [STK_AW-1:0]  stk_waddr, stk_raddr;
  logic [BYTE_W-1:0]  stk_wdata, stk_rdata;
  logic [STK_CW-1:0]  cnt_m2;

  logic               cell_wr;
  logic [POS_W:0]     fwd_sum;
  logic               stk_empty;

  tsm_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(TAPE_DEPTH)
  ) u_tape_ram (
    .clk  (clk),
    .we   (tape_we),
    .waddr(tape_waddr),
    .wdata(tape_wdata),
    .re   (tape_re),
    .raddr(tape_raddr),
    .rdata(tape_rdata)
  );

  tsm_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk  (clk),
    .we   (stk_we),
    .waddr(stk_waddr),
    .wdata(stk_wdata),
    .re   (stk_re),
    .raddr(stk_raddr),
    .rdata(stk_rdata)
  );

  assign fire     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !clr_active_r && (!in_vld_r || fire);
  assign accept   = in_valid && in_ready;

  assign in_vld_nxt  = accept ? 1'b1 : (fire ? 1'b0 : in_vld_r);
  assign out_vld_nxt = fire ? 1'b1 : (out_ready ? 1'b0 : out_vld_r);

  assign left_eff  = lpend_r ? tape_rdata : left_r;
  assign right_eff = rpend_r ? tape_rdata : right_r;
  assign top_eff   = tpend_r ? stk_rdata : top_r;
  assign stk_empty = (cnt_r == '0);

  assign ptr_x    = {1'b0, ptr_r};
  assign ptr_p1_x = ptr_x + (TAPE_AW + 1)'(1);
  assign ptr_p2_x = ptr_x + TAPE_TWO;
  assign ptr_m2_x = (ptr_x < TAPE_TWO) ? (ptr_x + TAPE_SIZE - TAPE_TWO) : (ptr_x - TAPE_TWO);
  assign ptr_inc  = (ptr_p1_x >= TAPE_SIZE) ? '0 : ptr_p1_x[TAPE_AW-1:0];
  assign ptr_dec  = (ptr_r == '0) ? TAPE_LAST : (ptr_r - TAPE_AW'(1));
  assign ptr_p2   = (ptr_p2_x >= TAPE_SIZE) ? TAPE_AW'(ptr_p2_x - TAPE_SIZE)
                                             : ptr_p2_x[TAPE_AW-1:0];
  assign ptr_m2   = ptr_m2_x[TAPE_AW-1:0];
  assign cnt_m2   = cnt_r - STK_CW'(2);
  assign fwd_sum  = {1'b0, in_pos_r} + {{(POS_W + 1 - BYTE_W){1'b0}}, top_eff};

  assign clr_active_nxt = clr_active_r && (clr_addr_r != TAPE_LAST);
  assign clr_addr_nxt   = clr_active_r ? (clr_addr_r + TAPE_AW'(1)) : clr_addr_r;

  always_comb begin
    ptr_nxt      = ptr_r;
    cell_nxt     = cell_r;
    left_nxt     = left_eff;
    right_nxt    = right_eff;
    lpend_nxt    = 1'b0;
    rpend_nxt    = 1'b0;
    top_nxt      = top_eff;
    tpend_nxt    = 1'b0;
    cnt_nxt      = cnt_r;
    halted_nxt   = halted_r;
    cell_wr      = 1'b0;
    tape_re      = 1'b0;
    tape_raddr   = ptr_p2;
    stk_we       = 1'b0;
    stk_waddr    = cnt_r[STK_AW-1:0];
    stk_wdata    = cell_r;
    stk_re       = 1'b0;
    stk_raddr    = cnt_m2[STK_AW-1:0];
    res_pos_nxt  = res_pos_r;
    res_byte_nxt = res_byte_r;
    res_ov_nxt   = res_ov_r;
    res_stat_nxt = res_stat_r;
    if (fire) begin
      res_pos_nxt  = in_pos_r;
      res_byte_nxt = '0;
      res_ov_nxt   = 1'b0;
      res_stat_nxt = ST_OK;
      if (halted_r) begin
        res_stat_nxt = ST_HALTED;
      end else begin
        case (in_cmd_r)
          CMD_INC: begin
            cell_nxt = cell_r + BYTE_W'(1);
            cell_wr  = 1'b1;
          end
          CMD_DEC: begin
            cell_nxt = cell_r - BYTE_W'(1);
            cell_wr  = 1'b1;
          end
          CMD_CLR: begin
            cell_nxt = '0;
            cell_wr  = 1'b1;
          end
          CMD_LEFT: begin
            ptr_nxt    = ptr_dec;
            cell_nxt   = left_eff;
            right_nxt  = cell_r;
            lpend_nxt  = 1'b1;
            tape_re    = 1'b1;
            tape_raddr = ptr_m2;
          end
          CMD_RIGHT: begin
            ptr_nxt    = ptr_inc;
            cell_nxt   = right_eff;
            left_nxt   = cell_r;
            rpend_nxt  = 1'b1;
            tape_re    = 1'b1;
            tape_raddr = ptr_p2;
          end
          CMD_PUSH: begin
            if (cnt_r == STK_FULL) begin
              res_stat_nxt = ST_OVERFLOW;
            end else begin
              stk_we  = 1'b1;
              top_nxt = cell_r;
              cnt_nxt = cnt_r + STK_CW'(1);
            end
          end
          CMD_POP: begin
            if (stk_empty) begin
              res_stat_nxt = ST_UNDERFLOW;
            end else begin
              cnt_nxt  = cnt_r - STK_CW'(1);
              cell_nxt = top_eff;
              cell_wr  = 1'b1;
              if (cnt_r >= STK_CW'(2)) begin
                stk_re    = 1'b1;
                tpend_nxt = 1'b1;
              end
            end
          end
          CMD_FWD: begin
            if (cell_r != '0) begin
              if (stk_empty) begin
                res_stat_nxt = ST_UNDERFLOW;
              end else if (fwd_sum <= {1'b0, plen_r}) begin
                res_pos_nxt = fwd_sum[POS_W-1:0];
              end else begin
                res_stat_nxt = ST_RANGE;
              end
            end
          end
          CMD_BACK: begin
            if (cell_r != '0) begin
              if (stk_empty) begin
                res_stat_nxt = ST_UNDERFLOW;
              end else if ({{(POS_W - BYTE_W){1'b0}}, top_eff} <= in_pos_r) begin
                res_pos_nxt = in_pos_r - {{(POS_W - BYTE_W){1'b0}}, top_eff};
              end else begin
                res_stat_nxt = ST_RANGE;
              end
            end
          end
          CMD_OUT: begin
            res_byte_nxt = cell_r;
            res_ov_nxt   = 1'b1;
          end
          default: begin
            res_stat_nxt = ST_ILLEGAL;
          end
        endcase
        if (res_stat_nxt != ST_OK) begin
          halted_nxt = 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (clr_active_r) begin
      tape_we    = 1'b1;
      tape_waddr = clr_addr_r;
      tape_wdata = '0;
    end else begin
      tape_we    = cell_wr;
      tape_waddr = ptr_r;
      tape_wdata = cell_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      plen_r       <= '0;
      ptr_r        <= '0;
      cell_r       <= '0;
      left_r       <= '0;
      right_r      <= '0;
      lpend_r      <= 1'b0;
      rpend_r      <= 1'b0;
      tpend_r      <= 1'b0;
      cnt_r        <= '0;
      halted_r     <= 1'b0;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else begin
      in_vld_r     <= in_vld_nxt;
      out_vld_r    <= out_vld_nxt;
      if (cfg_wr_en) begin
        plen_r <= cfg_wr_data;
      end
      ptr_r        <= ptr_nxt;
      cell_r       <= cell_nxt;
      left_r       <= left_nxt;
      right_r      <= right_nxt;
      lpend_r      <= lpend_nxt;
      rpend_r      <= rpend_nxt;
      tpend_r      <= tpend_nxt;
      cnt_r        <= cnt_nxt;
      halted_r     <= halted_nxt;
      clr_active_r <= clr_active_nxt;
      clr_addr_r   <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_cmd_r <= in_command;
      in_pos_r <= in_position;
    end
    top_r      <= top_nxt;
    res_pos_r  <= res_pos_nxt;
    res_byte_r <= res_byte_nxt;
    res_ov_r   <= res_ov_nxt;
    res_stat_r <= res_stat_nxt;
  end

  assign out_valid         = out_vld_r;
  assign out_next_position = res_pos_r;
  assign out_out_byte      = res_byte_r;
  assign out_out_valid     = res_ov_r;
  assign out_status        = res_stat_r;

endmodule
`default_nettype wire

@@ tb/tsm_execute_checker.sv @@
// Result checker for tape_stack_machine_execute: watches the instruction, result and
// register ports, predicts every result from its own model of tape, stack and halt state.
// Depends on tsm_pkg.
`timescale 1ns / 100ps
module tsm_execute_checker #(
  parameter int TAPE_DEPTH  = 4096,
  parameter int STACK_DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [tsm_pkg::POS_W-1:0]  cfg_wr_data,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [tsm_pkg::BYTE_W-1:0] in_command,
  input  logic [tsm_pkg::POS_W-1:0]  in_position,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [tsm_pkg::POS_W-1:0]  out_next_position,
  input  logic [tsm_pkg::BYTE_W-1:0] out_out_byte,
  input  logic                       out_out_valid,
  input  logic [tsm_pkg::STAT_W-1:0] out_status,
  output int                         mismatch_count,
  output int                         results_outstanding
);
  import tsm_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0]  next_position;
    logic [BYTE_W-1:0] out_byte;
    logic              out_valid;
    logic [STAT_W-1:0] status;
  } exec_result_t;

  logic [BYTE_W-1:0] tape_cells [TAPE_DEPTH];
  logic [BYTE_W-1:0] stack_mem [STACK_DEPTH];
  int                cell_ptr;
  int                stack_used;
  bit                halted;
  logic [POS_W-1:0]  program_length;
  exec_result_t      expected_results [$];
  int                mismatches = 0;

  assign mismatch_count = mismatches;

  function automatic exec_result_t execute_instruction(input logic [BYTE_W-1:0] cmd,
                                                       input logic [POS_W-1:0] pos);
    exec_result_t      res;
    logic [BYTE_W-1:0] cur_cell;
    int                top;
    int                p;
    int                limit;
    res.next_position = pos;
    res.out_byte = '0;
    res.out_valid = 1'b0;
    res.status = ST_OK;
    cur_cell = tape_cells[cell_ptr];
    p = pos;
    limit = program_length;
    if (halted) begin
      res.status = ST_HALTED;
    end else begin
      case (cmd)
        CMD_INC: tape_cells[cell_ptr] = cur_cell + 8'd1;
        CMD_DEC: tape_cells[cell_ptr] = cur_cell - 8'd1;
        CMD_CLR: tape_cells[cell_ptr] = '0;
        CMD_LEFT: cell_ptr = (cell_ptr == 0) ? TAPE_DEPTH - 1 : cell_ptr - 1;
        CMD_RIGHT: cell_ptr = (cell_ptr + 1 >= TAPE_DEPTH) ? 0 : cell_ptr + 1;
        CMD_PUSH: begin
          if (stack_used >= STACK_DEPTH) begin
            res.status = ST_OVERFLOW;
          end else begin
            stack_mem[stack_used] = cur_cell;
            stack_used++;
          end
        end
        CMD_POP: begin
          if (stack_used == 0) begin
            res.status = ST_UNDERFLOW;
          end else begin
            stack_used--;
            tape_cells[cell_ptr] = stack_mem[stack_used];
          end
        end
        CMD_FWD, CMD_BACK: begin
          if (cur_cell != 0) begin
            if (stack_used == 0) begin
              res.status = ST_UNDERFLOW;
            end else begin
              top = stack_mem[stack_used - 1];
              if (cmd == CMD_FWD) begin
                if (p + top <= limit) res.next_position = POS_W'(p + top);
                else res.status = ST_RANGE;
              end else begin
                if (top <= p) res.next_position = POS_W'(p - top);
                else res.status = ST_RANGE;
              end
            end
          end
        end
        CMD_OUT: begin
          res.out_byte = cur_cell;
          res.out_valid = 1'b1;
        end
        default: res.status = ST_ILLEGAL;
      endcase
      if (res.status != ST_OK) begin
        halted = 1'b1;
        res.next_position = pos;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    exec_result_t want;
    exec_result_t got;
    int           i;
    if (!rst_n) begin
      for (i = 0; i < TAPE_DEPTH; i++) tape_cells[i] = '0;
      cell_ptr = 0;
      stack_used = 0;
      halted = 1'b0;
      program_length = '0;
      expected_results.delete();
    end else begin
      if (cfg_wr_en) program_length = cfg_wr_data;
      if (out_valid && out_ready) begin
        got.next_position = out_next_position;
        got.out_byte = out_out_byte;
        got.out_valid = out_out_valid;
        got.status = out_status;
        if (expected_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result next_position=%0d byte=%0d valid=%0d status=%0d",
                     $time, got.next_position, got.out_byte, got.out_valid, got.status);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("%0t: result differs: expected next_position=%0d byte=%0d",
                       $time, want.next_position, want.out_byte);
              $display("  valid=%0d status=%0d, got next_position=%0d byte=%0d",
                       want.out_valid, want.status, got.next_position, got.out_byte);
              $display("  valid=%0d status=%0d", got.out_valid, got.status);
            end
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(execute_instruction(in_command, in_position));
    end
    results_outstanding <= expected_results.size();
  end

endmodule

@@ tb/tb_tape_stack_machine_execute.sv @@
// Top of the tape_stack_machine_execute testbench: clock, reset, instruction and register
// stimulus with random idling on both channels, and the final verdict.
// Depends on tsm_pkg, tape_stack_machine_execute and tsm_execute_checker.
`timescale 1ns / 100ps
module tb_tape_stack_machine_execute;
  import tsm_pkg::*;

  localparam int TAPE_DEPTH  = 4096;
  localparam int STACK_DEPTH = 1024;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  typedef enum int {
    HALT_OVERFLOW,
    HALT_POP_EMPTY,
    HALT_JUMP_EMPTY,
    HALT_FWD_RANGE,
    HALT_BACK_RANGE,
    HALT_ILLEGAL
  } halt_cause_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [POS_W-1:0]  cfg_wr_data;
  logic              in_valid;
  logic              in_ready;
  logic [BYTE_W-1:0] in_command;
  logic [POS_W-1:0]  in_position;
  logic              out_valid;
  logic              out_ready;
  logic [POS_W-1:0]  out_next_position;
  logic [BYTE_W-1:0] out_out_byte;
  logic              out_out_valid;
  logic [STAT_W-1:0] out_status;
  int                mismatch_count;
  int                results_outstanding;

  int                stack_fill;
  logic [POS_W-1:0]  prog_len;
  int                send_run_left;
  bit                send_quiet;
  int                recv_run_left;
  bit                recv_quiet;

  tape_stack_machine_execute #(
    .TAPE_DEPTH (TAPE_DEPTH),
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_position      (in_position),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_next_position(out_next_position),
    .out_out_byte     (out_out_byte),
    .out_out_valid    (out_out_valid),
    .out_status       (out_status)
  );

  tsm_execute_checker #(
    .TAPE_DEPTH (TAPE_DEPTH),
    .STACK_DEPTH(STACK_DEPTH)
  ) exec_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_position        (in_position),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_next_position  (out_next_position),
    .out_out_byte       (out_out_byte),
    .out_out_valid      (out_out_valid),
    .out_status         (out_status),
    .mismatch_count     (mismatch_count),
    .results_outstanding(results_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Idling comes in stretches: some stretches run back to back, the rest wait a random gap before each item.
  task automatic draw_gap(inout int run_left, inout bit quiet, output int gap);
    if (run_left == 0) begin
      run_left = $urandom_range(10, 60);
      quiet = ($urandom_range(0, 2) == 0);
    end
    run_left--;
    gap = quiet ? 0 : $urandom_range(0, 18);
  endtask

  task automatic issue(input logic [BYTE_W-1:0] cmd, input logic [POS_W-1:0] pos);
    int gap;
    draw_gap(send_run_left, send_quiet, gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_position <= pos;
    do @(posedge clk); while (!(in_valid && in_ready));
    if (cmd == CMD_PUSH) stack_fill++;
    if (cmd == CMD_POP) stack_fill--;
  endtask

  task automatic set_program_length(input logic [POS_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    prog_len = value;
  endtask

  initial begin
    int gap;
    out_ready <= 1'b0;
    recv_run_left = 0;
    recv_quiet = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      draw_gap(recv_run_left, recv_quiet, gap);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin
    int                seg;
    int                n;
    int                pick;
    logic [BYTE_W-1:0] cmd;
    logic [POS_W-1:0]  pos;
    halt_cause_t       cause;
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    in_valid <= 1'b0;
    in_command <= '0;
    in_position <= '0;
    stack_fill = 0;
    prog_len = '0;
    send_run_left = 0;
    send_quiet = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_program_length('0);
    issue(CMD_FWD, '0);
    issue(CMD_BACK, POS_MAX);
    issue(CMD_OUT, 20'd5);
    issue(CMD_DEC, 20'd6);
    issue(CMD_OUT, 20'd7);
    issue(CMD_INC, 20'd8);
    issue(CMD_INC, 20'd9);
    issue(CMD_LEFT, 20'd10);
    issue(CMD_INC, 20'd11);
    issue(CMD_INC, 20'd12);
    issue(CMD_RIGHT, 20'd13);
    issue(CMD_OUT, 20'd14);
    issue(CMD_PUSH, 20'd15);
    issue(CMD_CLR, 20'd16);
    issue(CMD_POP, 20'd17);
    issue(CMD_PUSH, 20'd18);
    issue(CMD_BACK, 20'd1);
    issue(CMD_OUT, POS_MAX);
    set_program_length(POS_MAX);
    issue(CMD_FWD, POS_MAX - 20'd1);
    issue(CMD_RIGHT, 20'd3);
    issue(CMD_DEC, 20'd4);
    issue(CMD_PUSH, 20'd5);
    issue(CMD_FWD, POS_MAX - 20'd255);
    issue(CMD_BACK, 20'd255);
    issue(CMD_BACK, POS_MAX);

    for (seg = 0; seg < 5; seg++) begin
      case (seg)
        0: set_program_length(POS_W'($urandom_range(510, POS_MAX)));
        1: set_program_length('0);
        2: set_program_length(POS_MAX);
        3: set_program_length(POS_W'($urandom_range(510, 2000)));
        default: set_program_length(POS_W'($urandom_range(0, 509)));
      endcase
      for (n = 0; n < 200; n++) begin
        pick = $urandom_range(0, 99);
        pos = POS_W'($urandom);
        if (pick < 20) cmd = CMD_INC;
        else if (pick < 30) cmd = CMD_DEC;
        else if (pick < 35) cmd = CMD_CLR;
        else if (pick < 45) cmd = CMD_LEFT;
        else if (pick < 55) cmd = CMD_RIGHT;
        else if (pick < 67) cmd = CMD_PUSH;
        else if (pick < 78) cmd = CMD_POP;
        else if (pick < 86) cmd = CMD_FWD;
        else if (pick < 94) cmd = CMD_BACK;
        else cmd = CMD_OUT;
        if (cmd == CMD_POP && stack_fill == 0) cmd = CMD_PUSH;
        if (cmd == CMD_PUSH && stack_fill == STACK_DEPTH) cmd = CMD_POP;
        if (cmd == CMD_FWD || cmd == CMD_BACK) begin
          if (stack_fill == 0 || (cmd == CMD_FWD && prog_len < 510)) begin
            // A cleared cell makes the jump a plain step whatever the stack holds.
            issue(CMD_CLR, POS_W'($urandom));
          end else if (cmd == CMD_FWD) begin
            pos = POS_W'($urandom_range(255, prog_len - 20'd255));
          end else begin
            pos = POS_W'($urandom_range(255, POS_MAX));
          end
        end
        issue(cmd, pos);
      end
    end

    cause = halt_cause_t'($urandom_range(0, 5));
    case (cause)
      HALT_OVERFLOW: begin
        while (stack_fill < STACK_DEPTH) issue(CMD_PUSH, POS_W'($urandom));
        issue(CMD_PUSH, POS_W'($urandom));
      end
      HALT_POP_EMPTY: begin
        while (stack_fill > 0) issue(CMD_POP, POS_W'($urandom));
        issue(CMD_POP, POS_W'($urandom));
      end
      HALT_JUMP_EMPTY: begin
        while (stack_fill > 0) issue(CMD_POP, POS_W'($urandom));
        issue(CMD_CLR, POS_W'($urandom));
        issue(CMD_INC, POS_W'($urandom));
        issue($urandom_range(0, 1) ? CMD_FWD : CMD_BACK, POS_W'($urandom));
      end
      HALT_FWD_RANGE, HALT_BACK_RANGE: begin
        if (stack_fill == STACK_DEPTH) issue(CMD_POP, POS_W'($urandom));
        issue(CMD_CLR, POS_W'($urandom));
        issue(CMD_INC, POS_W'($urandom));
        issue(CMD_PUSH, POS_W'($urandom));
        if (cause == HALT_FWD_RANGE) issue(CMD_FWD, prog_len);
        else issue(CMD_BACK, '0);
      end
      default: issue(BYTE_W'($urandom_range(0, 1) ? $urandom_range(0, 8'h61)
                                                  : $urandom_range(8'h74, 8'hff)),
                     POS_W'($urandom));
    endcase
    issue(8'hff, POS_W'($urandom));
    issue(8'h00, POS_W'($urandom));
    for (n = 0; n < 28; n++) issue(BYTE_W'($urandom), POS_W'($urandom));
    in_valid <= 1'b0;

    @(posedge clk);
    for (n = 0; n < 2000 && results_outstanding != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && results_outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ tape_stack_machine_execute.f @@
hw/rtl/tsm_pkg.sv
hw/rtl/tsm_ram.sv
hw/rtl/tape_stack_machine_execute.sv
tb/tsm_execute_checker.sv
tb/tb_tape_stack_machine_execute.sv
